[hw/rtl/rti_pkg.sv]
// Shared types, register codes and helper functions for the ray / triangle
// intersection unit. No dependencies.
package rti_pkg;

	localparam int CoordW  = 21;
	localparam int DivSteps = 61;

	typedef enum logic [2:0] {
		REG_VERTEX_A = 3'd0,
		REG_VERTEX_B = 3'd1,
		REG_VERTEX_C = 3'd2,
		REG_NORMAL   = 3'd3,
		REG_EPSILON  = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic              rej;
		logic [2:0][20:0]  o;
		logic [2:0][20:0]  d;
		logic [44:0]       rem;
		logic [60:0]       dvd;
		logic [60:0]       quo;
		logic [43:0]       den;
	} div_t;

	function automatic logic signed [20:0] comp(input logic [62:0] p, input logic [1:0] i);
		return $signed(p[CoordW*i +: CoordW]);
	endfunction

	function automatic div_t div_step(input div_t x);
		div_t        y;
		logic [45:0] t;
		y = x;
		t = {x.rem, x.dvd[60]};
		if (t >= {2'b00, x.den}) begin
			y.rem = 45'(t - {2'b00, x.den});
			y.quo = {x.quo[59:0], 1'b1};
		end else begin
			y.rem = t[44:0];
			y.quo = {x.quo[59:0], 1'b0};
		end
		y.dvd = {x.dvd[59:0], 1'b0};
		return y;
	endfunction

endpackage

[hw/rtl/ray_triangle_intersect.sv]
// Ray / triangle intersection unit, fully pipelined.
// Depends on rti_pkg for register codes, the divider step and field helpers.
//
// The unit accepts one ray per clock and returns one result word per ray, in
// order. The depth is set by the distance divider, a chain of 61 restoring
// stages that each settle one quotient bit; the remaining stages hold the dot
// products, the plane point and the inside test. A stall on the result side
// holds the whole pipeline. Triangle-derived terms are rebuilt from the
// registers after a write.
module ray_triangle_intersect
	import rti_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, zero padding
	input  logic [127:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// distance, hit_x, hit_y, hit_z, zero padding
	output logic [95:0]  m_axis_tdata,
	// hit, distance_valid
	output logic [1:0]   m_axis_tuser,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [62:0]  cfg_data
);

	logic [62:0] va_q, vb_q, vc_q, nrm_q;
	logic [19:0] eps_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			va_q  <= '0;
			vb_q  <= '0;
			vc_q  <= '0;
			nrm_q <= '0;
			eps_q <= 20'd1;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_VERTEX_A: va_q  <= cfg_data;
				REG_VERTEX_B: vb_q  <= cfg_data;
				REG_VERTEX_C: vc_q  <= cfg_data;
				REG_NORMAL:   nrm_q <= cfg_data;
				REG_EPSILON:  eps_q <= cfg_data[19:0];
				default: ;
			endcase
		end
	end

	logic signed [20:0] a_c [3];
	logic signed [20:0] b_c [3];
	logic signed [20:0] c_c [3];
	logic signed [20:0] n_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			a_c[i] = comp(va_q, 2'(i));
			b_c[i] = comp(vb_q, 2'(i));
			c_c[i] = comp(vc_q, 2'(i));
			n_c[i] = comp(nrm_q, 2'(i));
		end
	end

	// Triangle-side terms, rebuilt continuously from the registers.
	logic signed [21:0] u_q [3];
	logic signed [21:0] v_q [3];
	logic signed [41:0] nsq_q [3];
	logic signed [41:0] ne_q [3];
	logic        [39:0] ee_q;
	logic signed [44:0] tn_q [3];
	logic               deg_q;
	logic signed [12:0] off_q [3];
	logic signed [43:0] pvh_q [3][3];
	logic signed [45:0] pvl_q [3][3];
	logic signed [43:0] puh_q [3][3];
	logic signed [45:0] pul_q [3][3];
	logic signed [43:0] qhh_q [3];
	logic signed [45:0] qhl_q [3];
	logic signed [47:0] qll_q [3];
	logic signed [71:0] vn_q [3][3];
	logic signed [71:0] un_q [3][3];
	logic signed [95:0] qn_q [3];
	logic signed [71:0] g_q [3];
	logic signed [71:0] h_q [3];
	logic signed [95:0] qq_q;

	logic        [45:0] nsum;
	logic signed [21:0] nh [3];
	logic signed [23:0] nl [3];

	always_comb begin
		nsum = 46'($unsigned(nsq_q[0])) + 46'($unsigned(nsq_q[1])) + 46'($unsigned(nsq_q[2]));
		for (int i = 0; i < 3; i++) begin
			nh[i] = tn_q[i][44:23];
			nl[i] = $signed({1'b0, tn_q[i][22:0]});
		end
	end

	always_ff @(posedge clk) begin
		ee_q  <= 40'(eps_q) * 40'(eps_q);
		deg_q <= (nsum << 2) < 46'(ee_q);
		for (int i = 0; i < 3; i++) begin
			u_q[i]   <= 22'(b_c[i]) - 22'(a_c[i]);
			v_q[i]   <= 22'(c_c[i]) - 22'(a_c[i]);
			nsq_q[i] <= 42'(n_c[i]) * 42'(n_c[i]);
			ne_q[i]  <= 42'(n_c[i]) * $signed({22'd0, eps_q});
			off_q[i] <= 13'((ne_q[i] + (ne_q[i][41] ? 42'sd536870911 : 42'sd0)) >>> 29);
			qhh_q[i] <= 44'(nh[i]) * 44'(nh[i]);
			qhl_q[i] <= 46'(nh[i]) * 46'(nl[i]);
			qll_q[i] <= 48'(nl[i]) * 48'(nl[i]);
			qn_q[i]  <= (96'(qhh_q[i]) <<< 46) + (96'(qhl_q[i]) <<< 24) + 96'(qll_q[i]);
			for (int j = 0; j < 3; j++) begin
				pvh_q[i][j] <= 44'(v_q[i]) * 44'(nh[j]);
				pvl_q[i][j] <= 46'(v_q[i]) * 46'(nl[j]);
				puh_q[i][j] <= 44'(u_q[i]) * 44'(nh[j]);
				pul_q[i][j] <= 46'(u_q[i]) * 46'(nl[j]);
				vn_q[i][j]  <= (72'(pvh_q[i][j]) <<< 23) + 72'(pvl_q[i][j]);
				un_q[i][j]  <= (72'(puh_q[i][j]) <<< 23) + 72'(pul_q[i][j]);
			end
		end
		tn_q[0] <= 45'(u_q[1]) * 45'(v_q[2]) - 45'(u_q[2]) * 45'(v_q[1]);
		tn_q[1] <= 45'(u_q[2]) * 45'(v_q[0]) - 45'(u_q[0]) * 45'(v_q[2]);
		tn_q[2] <= 45'(u_q[0]) * 45'(v_q[1]) - 45'(u_q[1]) * 45'(v_q[0]);
		g_q[0]  <= vn_q[1][2] - vn_q[2][1];
		g_q[1]  <= vn_q[2][0] - vn_q[0][2];
		g_q[2]  <= vn_q[0][1] - vn_q[1][0];
		h_q[0]  <= un_q[2][1] - un_q[1][2];
		h_q[1]  <= un_q[0][2] - un_q[2][0];
		h_q[2]  <= un_q[1][0] - un_q[0][1];
		qq_q    <= qn_q[0] + qn_q[1] + qn_q[2];
	end

	// Ray pipeline.
	logic en;
	logic out_vld_q;

	assign en            = !out_vld_q || m_axis_tready;
	assign s_axis_tready = en;

	logic               vld_s1, vld_s2, vld_s3;
	logic signed [20:0] o_s1 [3];
	logic signed [20:0] d_s1 [3];
	logic signed [21:0] w0_s1 [3];
	logic signed [20:0] o_s2 [3];
	logic signed [20:0] d_s2 [3];
	logic signed [42:0] pa_s2 [3];
	logic signed [41:0] pb_s2 [3];
	logic signed [20:0] o_s3 [3];
	logic signed [20:0] d_s3 [3];
	logic signed [44:0] a_s3;
	logic signed [43:0] b_s3;

	logic               dq_vld [DivSteps+1];
	div_t               dq_s [DivSteps+1];

	logic [44:0] absa;
	logic [43:0] absb;
	logic        rej;

	always_comb begin
		absa = a_s3[44] ? 45'(-a_s3) : 45'(a_s3);
		absb = b_s3[43] ? 44'(-b_s3) : 44'(b_s3);
		rej  = (b_s3 == '0) || (absb < {15'd0, eps_q, 9'd0}) || (a_s3 == '0) ||
			(a_s3[44] != b_s3[43]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				o_s1[i]  <= $signed(s_axis_tdata[21*i +: 21]);
				d_s1[i]  <= $signed(s_axis_tdata[63 + 21*i +: 21]);
				w0_s1[i] <= 22'($signed(s_axis_tdata[21*i +: 21])) - 22'(a_c[i]);
				o_s2[i]  <= o_s1[i];
				d_s2[i]  <= d_s1[i];
				pa_s2[i] <= 43'(n_c[i]) * 43'(w0_s1[i]);
				pb_s2[i] <= 42'(n_c[i]) * 42'(d_s1[i]);
				o_s3[i]  <= o_s2[i];
				d_s3[i]  <= d_s2[i];
				dq_s[0].o[i] <= o_s3[i];
				dq_s[0].d[i] <= d_s3[i];
			end
			a_s3 <= 45'sd0 - 45'(pa_s2[0]) - 45'(pa_s2[1]) - 45'(pa_s2[2]);
			b_s3 <= 44'(pb_s2[0]) + 44'(pb_s2[1]) + 44'(pb_s2[2]);
			dq_s[0].rej <= rej;
			dq_s[0].rem <= '0;
			dq_s[0].dvd <= {absa, 16'd0};
			dq_s[0].quo <= '0;
			dq_s[0].den <= absb;
			for (int k = 0; k < DivSteps; k++) begin
				dq_s[k+1] <= div_step(dq_s[k]);
			end
		end
	end

	// Distance and plane point.
	logic               vld_s5, vld_s6, vld_s7, vld_s8, vld_s9, vld_s10;
	logic               dv_s5, dv_s6, dv_s7, dv_s8, dv_s9, dv_s10;
	logic        [31:0] dist_s5, dist_s6, dist_s7, dist_s8, dist_s9, dist_s10;
	logic        [40:0] rc_s5;
	logic signed [20:0] o_s5 [3];
	logic signed [20:0] d_s5 [3];
	logic signed [20:0] o_s6 [3];
	logic signed [42:0] pl_s6 [3];
	logic signed [41:0] ph_s6 [3];
	logic signed [20:0] o_s7 [3];
	logic signed [63:0] prod_s7 [3];
	logic signed [20:0] o_s8 [3];
	logic signed [47:0] t_s8 [3];
	logic signed [47:0] p_s9 [3];
	logic               far_s10;
	logic signed [23:0] w_s10 [3];
	logic signed [20:0] h_s10 [3];

	logic [60:0]        q_end;
	logic signed [47:0] hs [3];
	logic               far;

	always_comb begin
		q_end = dq_s[DivSteps].quo;
		far   = 1'b0;
		for (int i = 0; i < 3; i++) begin
			hs[i] = p_s9[i] + 48'(off_q[i]);
			if (p_s9[i] >= 48'sd4194304 || p_s9[i] <= -48'sd4194304) begin
				far = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_s5   <= !dq_s[DivSteps].rej && !deg_q;
			dist_s5 <= (q_end > 61'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : q_end[31:0];
			rc_s5   <= (q_end > 61'h100_0000_0000) ? 41'h100_0000_0000 : q_end[40:0];
			dv_s6   <= dv_s5;
			dv_s7   <= dv_s6;
			dv_s8   <= dv_s7;
			dv_s9   <= dv_s8;
			dv_s10  <= dv_s9;
			dist_s6 <= dist_s5;
			dist_s7 <= dist_s6;
			dist_s8 <= dist_s7;
			dist_s9 <= dist_s8;
			dist_s10 <= dist_s9;
			far_s10 <= far;
			for (int i = 0; i < 3; i++) begin
				o_s5[i]    <= $signed(dq_s[DivSteps].o[i]);
				d_s5[i]    <= $signed(dq_s[DivSteps].d[i]);
				o_s6[i]    <= o_s5[i];
				pl_s6[i]   <= 43'(d_s5[i]) * $signed({22'd0, rc_s5[20:0]});
				ph_s6[i]   <= 42'(d_s5[i]) * $signed({22'd0, rc_s5[40:21]});
				o_s7[i]    <= o_s6[i];
				prod_s7[i] <= (64'(ph_s6[i]) <<< 21) + 64'(pl_s6[i]);
				o_s8[i]    <= o_s7[i];
				t_s8[i]    <= 48'((prod_s7[i] + (prod_s7[i][63] ? 64'sd65535 : 64'sd0)) >>> 16);
				p_s9[i]    <= 48'(o_s8[i]) + t_s8[i];
				w_s10[i]   <= 24'(p_s9[i] - 48'(a_c[i]));
				if (hs[i] > 48'sd1048575) begin
					h_s10[i] <= 21'sd1048575;
				end else if (hs[i] < -48'sd1048576) begin
					h_s10[i] <= -21'sd1048576;
				end else begin
					h_s10[i] <= hs[i][20:0];
				end
			end
		end
	end

	// Inside test: s = w . (v x N), t = w . (N x u), against Q = N . N.
	logic               vld_s11, vld_s12, vld_s13, vld_s14;
	logic               dv_s11, dv_s12, dv_s13, dv_s14;
	logic               far_s11, far_s12, far_s13, far_s14;
	logic        [31:0] dist_s11, dist_s12, dist_s13, dist_s14;
	logic signed [20:0] h_s11 [3];
	logic signed [20:0] h_s12 [3];
	logic signed [20:0] h_s13 [3];
	logic signed [20:0] h_s14 [3];
	logic signed [48:0] pwg_s11 [3][3];
	logic signed [48:0] pwh_s11 [3][3];
	logic signed [95:0] wg_s12 [3];
	logic signed [95:0] wh_s12 [3];
	logic signed [95:0] sn_s13, tn_s13;
	logic               in_s14;

	logic signed [24:0] gk [3][3];
	logic signed [24:0] hk [3][3];
	logic signed [95:0] rest, rt;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			gk[c][0] = $signed({1'b0, g_q[c][23:0]});
			gk[c][1] = $signed({1'b0, g_q[c][47:24]});
			gk[c][2] = 25'($signed(g_q[c][71:48]));
			hk[c][0] = $signed({1'b0, h_q[c][23:0]});
			hk[c][1] = $signed({1'b0, h_q[c][47:24]});
			hk[c][2] = 25'($signed(h_q[c][71:48]));
		end
		rest = qq_q - sn_s13;
		rt   = qq_q - sn_s13 - tn_s13;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_s11   <= dv_s10;
			dv_s12   <= dv_s11;
			dv_s13   <= dv_s12;
			dv_s14   <= dv_s13;
			far_s11  <= far_s10;
			far_s12  <= far_s11;
			far_s13  <= far_s12;
			far_s14  <= far_s13;
			dist_s11 <= dist_s10;
			dist_s12 <= dist_s11;
			dist_s13 <= dist_s12;
			dist_s14 <= dist_s13;
			for (int c = 0; c < 3; c++) begin
				h_s11[c] <= h_s10[c];
				h_s12[c] <= h_s11[c];
				h_s13[c] <= h_s12[c];
				h_s14[c] <= h_s13[c];
				for (int k = 0; k < 3; k++) begin
					pwg_s11[c][k] <= 49'(w_s10[c]) * 49'(gk[c][k]);
					pwh_s11[c][k] <= 49'(w_s10[c]) * 49'(hk[c][k]);
				end
				wg_s12[c] <= (96'(pwg_s11[c][2]) <<< 48) + (96'(pwg_s11[c][1]) <<< 24) +
					96'(pwg_s11[c][0]);
				wh_s12[c] <= (96'(pwh_s11[c][2]) <<< 48) + (96'(pwh_s11[c][1]) <<< 24) +
					96'(pwh_s11[c][0]);
			end
			sn_s13 <= wg_s12[0] + wg_s12[1] + wg_s12[2];
			tn_s13 <= wh_s12[0] + wh_s12[1] + wh_s12[2];
			in_s14 <= (sn_s13 > 96'sd0) && (tn_s13 > 96'sd0) && (rest > 96'sd0) &&
				(rt > 96'sd0);
		end
	end

	// Valid bits and the result word register.
	logic        hit_q, dv_q;
	logic [31:0] dist_q;
	logic [20:0] hx_q, hy_q, hz_q;
	logic        hit;

	assign hit = dv_s14 && !far_s14 && in_s14;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			for (int k = 0; k <= DivSteps; k++) begin
				dq_vld[k] <= 1'b0;
			end
			vld_s5    <= 1'b0;
			vld_s6    <= 1'b0;
			vld_s7    <= 1'b0;
			vld_s8    <= 1'b0;
			vld_s9    <= 1'b0;
			vld_s10   <= 1'b0;
			vld_s11   <= 1'b0;
			vld_s12   <= 1'b0;
			vld_s13   <= 1'b0;
			vld_s14   <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_s1    <= s_axis_tvalid;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			dq_vld[0] <= vld_s3;
			for (int k = 0; k < DivSteps; k++) begin
				dq_vld[k+1] <= dq_vld[k];
			end
			vld_s5    <= dq_vld[DivSteps];
			vld_s6    <= vld_s5;
			vld_s7    <= vld_s6;
			vld_s8    <= vld_s7;
			vld_s9    <= vld_s8;
			vld_s10   <= vld_s9;
			vld_s11   <= vld_s10;
			vld_s12   <= vld_s11;
			vld_s13   <= vld_s12;
			vld_s14   <= vld_s13;
			out_vld_q <= vld_s14;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_q  <= hit;
			dv_q   <= dv_s14;
			dist_q <= dv_s14 ? dist_s14 : 32'd0;
			hx_q   <= hit ? h_s14[0] : 21'd0;
			hy_q   <= hit ? h_s14[1] : 21'd0;
			hz_q   <= hit ? h_s14[2] : 21'd0;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {1'b0, hz_q, hy_q, hx_q, dist_q};
	assign m_axis_tuser  = {dv_q, hit_q};

endmodule

[tb/tb_top.sv]
// Self-checking testbench for ray_triangle_intersect: stream rays through a
// set of triangle settings and compare each result word with a local model.
// Depends on rti_pkg and the ray_triangle_intersect RTL.
`timescale 1ns / 100ps

module tb_top;
	import rti_pkg::*;

	typedef logic signed [127:0] s128_t;

	typedef struct {
		logic        hit;
		logic        dist_ok;
		logic [31:0] distance;
		logic [20:0] hx, hy, hz;
	} isect_t;

	class isect_board;
		logic [62:0] tri_a, tri_b, tri_c, nrm;
		logic [19:0] eps;
		isect_t      awaited[$];
		int          errors;

		function new();
			tri_a = '0; tri_b = '0; tri_c = '0; nrm = '0; eps = 20'd1; errors = 0;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [62:0] val);
			case (idx)
				REG_VERTEX_A: tri_a = val;
				REG_VERTEX_B: tri_b = val;
				REG_VERTEX_C: tri_c = val;
				REG_NORMAL:   nrm = val;
				REG_EPSILON:  eps = val[19:0];
				default: ;
			endcase
		endfunction

		function longint coord(logic [62:0] v, int i);
			logic signed [20:0] c;
			c = v[21*i +: 21];
			return longint'(c);
		endfunction

		function void note(logic [127:0] word);
			isect_t r;
			longint o[3], d[3], a[3], n[3], u[3], v[3], w[3], p[3];
			longint nx[3], wv[3], uw[3];
			longint e, nsq, pa, pb, absa, absb, h;
			logic [63:0] q, rc;
			s128_t qq, sn, tn;
			logic signed [20:0] f;
			r = '{default: '0};
			e = longint'(eps);
			nsq = 0; pa = 0; pb = 0;
			for (int i = 0; i < 3; i++) begin
				f = word[21*i +: 21];
				o[i] = f;
				f = word[63 + 21*i +: 21];
				d[i] = f;
				a[i] = coord(tri_a, i);
				n[i] = coord(nrm, i);
				u[i] = coord(tri_b, i) - a[i];
				v[i] = coord(tri_c, i) - a[i];
				nsq += n[i] * n[i];
				pa -= n[i] * (o[i] - a[i]);
				pb += n[i] * d[i];
			end
			absa = pa < 0 ? -pa : pa;
			absb = pb < 0 ? -pb : pb;
			if (nsq * 4 < e * e || pb == 0 || absb < e * 512 || pa == 0 ||
					((pa < 0) != (pb < 0))) begin
				awaited.push_back(r);
				return;
			end
			q = (64'(absa) << 16) / 64'(absb);
			r.dist_ok = 1'b1;
			r.distance = q > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : q[31:0];
			rc = q > (64'd1 << 40) ? (64'd1 << 40) : q;
			for (int i = 0; i < 3; i++) begin
				p[i] = o[i] + (d[i] * longint'(rc)) / 65536;
				if (p[i] >= (64'sd1 <<< 22) || p[i] <= -(64'sd1 <<< 22)) begin
					awaited.push_back(r);
					return;
				end
				w[i] = p[i] - a[i];
			end
			for (int i = 0; i < 3; i++) begin
				int j, k;
				j = (i + 1) % 3;
				k = (i + 2) % 3;
				nx[i] = u[j] * v[k] - u[k] * v[j];
				wv[i] = w[j] * v[k] - w[k] * v[j];
				uw[i] = u[j] * w[k] - u[k] * w[j];
			end
			qq = 0; sn = 0; tn = 0;
			for (int i = 0; i < 3; i++) begin
				qq += s128_t'(nx[i]) * s128_t'(nx[i]);
				sn += s128_t'(wv[i]) * s128_t'(nx[i]);
				tn += s128_t'(uw[i]) * s128_t'(nx[i]);
			end
			if (sn > 0 && tn > 0 && qq - sn - tn > 0) begin
				r.hit = 1'b1;
				for (int i = 0; i < 3; i++) begin
					h = p[i] + (n[i] * e) / (64'sd1 <<< 29);
					if (h > 1048575) h = 1048575;
					if (h < -1048576) h = -1048576;
					if (i == 0) r.hx = h[20:0];
					else if (i == 1) r.hy = h[20:0];
					else r.hz = h[20:0];
				end
			end
			awaited.push_back(r);
		endfunction

		function void check(logic [95:0] word, logic [1:0] flags);
			isect_t x;
			if (awaited.size() == 0) begin
				$error("result word with no ray outstanding");
				errors++;
				return;
			end
			x = awaited.pop_front();
			if (flags[0] !== x.hit) begin
				$error("hit: expected %0d, got %0d", x.hit, flags[0]); errors++;
			end
			if (flags[1] !== x.dist_ok) begin
				$error("distance_valid: expected %0d, got %0d", x.dist_ok, flags[1]);
				errors++;
			end
			if (word[31:0] !== x.distance) begin
				$error("distance: expected %0h, got %0h", x.distance, word[31:0]); errors++;
			end
			if (word[52:32] !== x.hx) begin
				$error("hit_x: expected %0h, got %0h", x.hx, word[52:32]); errors++;
			end
			if (word[73:53] !== x.hy) begin
				$error("hit_y: expected %0h, got %0h", x.hy, word[73:53]); errors++;
			end
			if (word[94:74] !== x.hz) begin
				$error("hit_z: expected %0h, got %0h", x.hz, word[94:74]); errors++;
			end
		endfunction
	endclass

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [95:0]  m_axis_tdata;
	logic [1:0]   m_axis_tuser;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [2:0]   cfg_index = REG_VERTEX_A;
	logic [62:0]  cfg_data = '0;

	isect_board board = new();
	int send_idle = 0;
	int recv_stall = 0;
	longint cycles = 0;

	ray_triangle_intersect u_dut (.*);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("ray_triangle_intersect regression: fail");
			$finish;
		end
	end

	always @(posedge clk)
		m_axis_tready <= ($urandom_range(99) >= recv_stall);

	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			board.note(s_axis_tdata);
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check(m_axis_tdata, m_axis_tuser);
		if (arst_n && cfg_valid && cfg_ready)
			board.set_reg(cfg_reg_t'(cfg_index), cfg_data);
	end

	function automatic logic [62:0] pack3(longint x, longint y, longint z);
		return {z[20:0], y[20:0], x[20:0]};
	endfunction

	task automatic write_reg(cfg_reg_t idx, logic [62:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (board.awaited.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic set_triangle(logic [62:0] a, logic [62:0] b, logic [62:0] c,
			logic [62:0] n, logic [19:0] e);
		drain();
		write_reg(REG_VERTEX_A, a);
		write_reg(REG_VERTEX_B, b);
		write_reg(REG_VERTEX_C, c);
		write_reg(REG_NORMAL, n);
		write_reg(REG_EPSILON, {43'd0, e});
		cfg_valid <= 1'b0;
		repeat (8) @(posedge clk);
	endtask

	// A true unit normal of the triangle, scaled to Q1.19; +Z for a degenerate one.
	function automatic logic [62:0] normal_of(logic [62:0] a, logic [62:0] b, logic [62:0] c);
		real u[3], v[3], nx[3], len;
		for (int i = 0; i < 3; i++) begin
			u[i] = board.coord(b, i) - board.coord(a, i);
			v[i] = board.coord(c, i) - board.coord(a, i);
		end
		nx[0] = u[1] * v[2] - u[2] * v[1];
		nx[1] = u[2] * v[0] - u[0] * v[2];
		nx[2] = u[0] * v[1] - u[1] * v[0];
		len = $sqrt(nx[0] * nx[0] + nx[1] * nx[1] + nx[2] * nx[2]);
		if (len == 0.0) return pack3(0, 0, 524288);
		return pack3(longint'(nx[0] / len * 524287.0), longint'(nx[1] / len * 524287.0),
			longint'(nx[2] / len * 524287.0));
	endfunction

	task automatic send(longint ox, longint oy, longint oz, longint dx, longint dy, longint dz);
		s_axis_tdata <= {2'b00, pack3(dx, dy, dz), pack3(ox, oy, oz)};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		if ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
	endtask

	task automatic send_raw(logic [127:0] w);
		send(longint'($signed(w[20:0])), longint'($signed(w[41:21])),
			longint'($signed(w[62:42])), longint'($signed(w[83:63])),
			longint'($signed(w[104:84])), longint'($signed(w[125:105])));
	endtask

	function automatic longint clip21(longint x);
		return x > 1048575 ? 1048575 : (x < -1048576 ? -1048576 : x);
	endfunction

	// Mostly rays aimed at a point in or near the triangle, the rest noise.
	task automatic random_rays(int count);
		longint t[3], off[3], s, r, k;
		for (int j = 0; j < count; j++) begin
			if ($urandom_range(99) < 25) begin
				send_raw({$urandom, $urandom, $urandom, $urandom});
			end else begin
				s = $urandom_range(300);
				r = $urandom_range(300 - s);
				k = $urandom_range(8, 1);
				for (int i = 0; i < 3; i++) begin
					t[i] = board.coord(board.tri_a, i) +
						((board.coord(board.tri_b, i) - board.coord(board.tri_a, i)) * s +
						(board.coord(board.tri_c, i) - board.coord(board.tri_a, i)) * r) / 256;
					off[i] = longint'($urandom_range(65536)) - 32768;
				end
				if ($urandom_range(9) == 0) k = -k;
				send(clip21(t[0] + off[0]), clip21(t[1] + off[1]), clip21(t[2] + off[2]),
					clip21(-off[0] * k / 4), clip21(-off[1] * k / 4), clip21(-off[2] * k / 4));
			end
		end
	endtask

	task automatic set_phase(int ph);
		case (ph % 4)
			0: begin send_idle = 0; recv_stall = 0; end
			1: begin send_idle = 57; recv_stall = 0; end
			2: begin send_idle = 0; recv_stall = 57; end
			default: begin send_idle = 30; recv_stall = 30; end
		endcase
	endtask

	initial begin
		logic [62:0] ra, rb, rc;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: zero normal, every ray is rejected.
		random_rays(15);

		set_triangle(pack3(0, 0, 0), pack3(4096, 0, 0), pack3(0, 4096, 0),
			pack3(0, 0, 524288), 20'd0);
		send(1024, 1024, 5120, 0, 0, -1024);
		send(1024, 1024, 5120, 0, 0, 1024);
		send(1024, 1024, 5120, 1024, 0, 0);
		send(1024, 1024, 5120, 0, 0, 0);
		send(1024, 1024, 0, 0, 0, -1024);
		send(1024, 1024, 1048575, 0, 0, -1);
		send(-1048576, -1048576, -1048576, 1048575, 1048575, 1048575);
		send(1048575, 1048575, 1048575, -1048576, -1048576, -1048576);
		send(3000, 3000, 1024, 0, 0, -1024);
		send(0, 0, 1024, 0, 0, -1024);
		send(4096, 0, 1024, 0, 0, -1024);
		send(1024, 1024, 1048575, 1048575, 0, -1024);
		send(1048575, 1048575, 1048575, -1048576, -1048576, -1);
		set_triangle(pack3(0, 0, 0), pack3(4096, 0, 0), pack3(0, 4096, 0),
			pack3(0, 0, 524287), 20'hFFFFF);
		send(1024, 1024, 5120, 0, 0, -1024);
		send(1024, 1024, 5120, 0, 0, -4);
		send(1048575, 1048575, -1048576, 0, 0, 1048575);
		set_triangle(pack3(0, 0, 0), pack3(4096, 0, 0), pack3(8192, 0, 0),
			pack3(0, 0, 524288), 20'd1);
		send(1024, 0, 5120, 0, 0, -1024);
		set_triangle(pack3(0, 0, 0), pack3(4096, 0, 0), pack3(0, 4096, 0),
			pack3(1, 0, 0), 20'd3);
		send(1024, 1024, 5120, 0, 0, -1024);

		for (int ph = 0; ph < 12; ph++) begin
			set_phase(ph);
			if (ph % 3 == 2) begin
				ra = 63'({$urandom, $urandom});
				rb = 63'({$urandom, $urandom});
				rc = 63'({$urandom, $urandom});
				set_triangle(ra, rb, rc, 63'({$urandom, $urandom}), 20'($urandom));
			end else begin
				ra = pack3(longint'($urandom_range(131072)) - 65536,
					longint'($urandom_range(131072)) - 65536,
					longint'($urandom_range(131072)) - 65536);
				rb = pack3(board.coord(ra, 0) + $urandom_range(65536) - 32768,
					board.coord(ra, 1) + $urandom_range(65536) - 32768,
					board.coord(ra, 2) + $urandom_range(65536) - 32768);
				rc = pack3(board.coord(ra, 0) + $urandom_range(65536) - 32768,
					board.coord(ra, 1) + $urandom_range(65536) - 32768,
					board.coord(ra, 2) + $urandom_range(65536) - 32768);
				set_triangle(ra, rb, rc, normal_of(ra, rb, rc),
					ph == 0 ? 20'd0 : (ph == 4 ? 20'hFFFFF : 20'($urandom_range(4095))));
			end
			random_rays(ph % 4 == 0 ? 90 : 50);
		end

		drain();
		if (board.errors == 0 && board.awaited.size() == 0)
			$display("ray_triangle_intersect regression: pass");
		else
			$display("ray_triangle_intersect regression: fail");
		$finish;
	end

endmodule
